// ===== sv/running_median_two_heaps_unit_macros.svh =====
// Assertion macros for the running median block
`ifndef RUNNING_MEDIAN_TWO_HEAPS_UNIT_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RM_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RM_ASSERT(label, clk, rst_n, prop, msg)
`define RM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== sv/rmth_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rmth_pkg;
    localparam int CAPACITY = 1024;
    localparam int HEAP_DEPTH = CAPACITY / 2 + 2;
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int SW = $clog2(HEAP_DEPTH + 1);
    localparam int TW = $clog2(CAPACITY + 1);

    typedef logic signed [31:0] sample_t;
    typedef logic [AW-1:0] addr_t;
    typedef logic [SW-1:0] size_t;

    // Command from sequencer to a heap engine
    typedef struct packed {
        logic    push;
        logic    pop;
        sample_t value;
    } heap_cmd_t;

    // Status from a heap engine
    typedef struct packed {
        logic    busy;
        sample_t top;
        size_t   size;
    } heap_stat_t;
endpackage
`default_nettype wire

// ===== sv/rmth_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface rmth_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface rmth_out_if;
    logic valid;
    logic ready;
    logic signed [32:0] median_doubled;
    logic [10:0] stored_count;
    logic rejected;
    modport source (output valid, output median_doubled, output stored_count,
        output rejected, input ready);
    modport sink (input valid, input median_doubled, input stored_count,
        input rejected, output ready);
endinterface
`default_nettype wire

// ===== sv/rmth_heap.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "running_median_two_heaps_unit_macros.svh"
// One heap in a memory with a single compare unit; sifts one level at a time.
module rmth_heap (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                is_max,
    input  wire rmth_pkg::heap_cmd_t cmd,
    output rmth_pkg::heap_stat_t     stat
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_UP_RD = 4'd1;
    localparam logic [3:0] S_UP_CMP = 4'd2;
    localparam logic [3:0] S_DN_RDL = 4'd3;
    localparam logic [3:0] S_DN_RDR = 4'd4;
    localparam logic [3:0] S_DN_CL = 4'd5;
    localparam logic [3:0] S_DN_CR = 4'd6;
    localparam logic [3:0] S_DN_SW = 4'd7;
    localparam logic [3:0] S_TOP = 4'd8;
    localparam logic [3:0] S_TOP_W = 4'd9;
    localparam logic [3:0] S_POP_RD = 4'd10;
    localparam logic [3:0] S_POP_W = 4'd11;

    rmth_pkg::sample_t mem [rmth_pkg::HEAP_DEPTH];
    rmth_pkg::sample_t rd_q;
    rmth_pkg::addr_t   rd_addr;
    logic              wr_en;
    rmth_pkg::addr_t   wr_addr;
    rmth_pkg::sample_t wr_data;

    logic [3:0]        state_reg, state_next;
    rmth_pkg::size_t   size_reg, size_next;
    rmth_pkg::addr_t   idx_reg, idx_next;
    rmth_pkg::addr_t   best_reg, best_next;
    rmth_pkg::sample_t cur_reg, cur_next;
    rmth_pkg::sample_t bv_reg, bv_next;

    // Shared compare: a ranks above b
    rmth_pkg::sample_t cmp_a, cmp_b;
    logic above;
    assign above = is_max ? (cmp_a > cmp_b) : (cmp_a < cmp_b);

    // Memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    logic [rmth_pkg::AW:0] lchild, rchild;
    rmth_pkg::addr_t parent;
    assign lchild = {idx_reg, 1'b1};
    assign rchild = lchild + 1'b1;
    assign parent = (idx_reg - 1'b1) >> 1;

    always_comb
    begin
        state_next = state_reg;
        size_next = size_reg;
        idx_next = idx_reg;
        best_next = best_reg;
        cur_next = cur_reg;
        bv_next = bv_reg;
        rd_addr = parent;
        wr_en = 1'b0;
        wr_addr = idx_reg;
        wr_data = cur_reg;
        cmp_a = cur_reg;
        cmp_b = rd_q;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.push)
                begin
                    // place at the end, sift up
                    idx_next = size_reg[rmth_pkg::AW-1:0];
                    cur_next = cmd.value;
                    size_next = size_reg + 1'b1;
                    wr_en = 1'b1;
                    wr_addr = size_reg[rmth_pkg::AW-1:0];
                    wr_data = cmd.value;
                    state_next = (size_reg == '0) ? S_TOP : S_UP_RD;
                end
                else if (cmd.pop)
                begin
                    size_next = size_reg - 1'b1;
                    rd_addr = rmth_pkg::addr_t'(size_reg - 1'b1);
                    idx_next = '0;
                    state_next = S_POP_RD;
                end
            end
            S_UP_RD:
            begin
                state_next = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                // swap with parent if the new value ranks above it
                if (above)
                begin
                    wr_en = 1'b1;
                    wr_addr = idx_reg;
                    wr_data = rd_q;
                    idx_next = parent;
                    state_next = S_TOP_W;
                end
                else
                begin
                    state_next = S_TOP;
                end
            end
            S_TOP_W:
            begin
                wr_en = 1'b1;
                wr_addr = idx_reg;
                wr_data = cur_reg;
                state_next = (idx_reg == '0) ? S_TOP : S_UP_RD;
            end
            S_POP_RD:
            begin
                // move last entry to the root
                cur_next = rd_q;
                state_next = S_POP_W;
            end
            S_POP_W:
            begin
                wr_en = (size_reg != '0);
                wr_addr = '0;
                wr_data = cur_reg;
                state_next = S_DN_RDL;
            end
            S_DN_RDL:
            begin
                best_next = idx_reg;
                bv_next = cur_reg;
                rd_addr = lchild[rmth_pkg::AW-1:0];
                state_next = (lchild < {1'b0, size_reg}) ? S_DN_RDR : S_TOP;
            end
            S_DN_RDR:
            begin
                // hold the left read so it lands for the left compare
                rd_addr = lchild[rmth_pkg::AW-1:0];
                state_next = S_DN_CL;
            end
            S_DN_CL:
            begin
                rd_addr = rchild[rmth_pkg::AW-1:0];
                cmp_a = rd_q;
                cmp_b = bv_reg;
                if (above)
                begin
                    best_next = lchild[rmth_pkg::AW-1:0];
                    bv_next = rd_q;
                end
                state_next = S_DN_CR;
            end
            S_DN_CR:
            begin
                cmp_a = rd_q;
                cmp_b = bv_reg;
                if (rchild < {1'b0, size_reg} && above)
                begin
                    best_next = rchild[rmth_pkg::AW-1:0];
                    bv_next = rd_q;
                end
                state_next = S_DN_SW;
            end
            S_DN_SW:
            begin
                cmp_a = bv_reg;
                if (best_next == idx_reg && best_reg == idx_reg)
                begin
                    state_next = S_TOP;
                end
                else
                begin
                    wr_en = 1'b1;
                    wr_addr = idx_reg;
                    wr_data = bv_reg;
                    idx_next = best_reg;
                    state_next = S_TOP_W;
                end
            end
            S_TOP:
            begin
                rd_addr = '0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // S_TOP_W after a sift-down continues downward
        if (state_reg == S_TOP_W && best_reg == idx_reg && idx_reg != '0)
        begin
            state_next = S_DN_RDL;
        end
    end

    // Track direction: best_reg==idx_reg marks a sift-down write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            size_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        cur_reg <= cur_next;
        bv_reg <= bv_next;
        if (state_reg == S_UP_CMP || state_reg == S_IDLE)
        begin
            best_reg <= ~idx_next;
        end
        else
        begin
            best_reg <= best_next;
        end
    end

    // Top follows the root read after every operation
    logic top_vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_vld_reg <= 1'b0;
        end
        else
        begin
            top_vld_reg <= (state_reg == S_TOP);
        end
    end

    rmth_pkg::sample_t top_hold_reg;
    always_ff @(posedge clk)
    begin
        if (top_vld_reg)
        begin
            top_hold_reg <= rd_q;
        end
    end

    assign stat.busy = (state_reg != S_IDLE) || top_vld_reg;
    assign stat.top = top_hold_reg;
    assign stat.size = size_reg;

    `RM_ASSERT(a_size_bound, clk, rst_n, size_reg <= rmth_pkg::SW'(rmth_pkg::HEAP_DEPTH),
        "heap size beyond depth")
    `RM_ASSERT(a_cmd_idle, clk, rst_n, (cmd.push || cmd.pop) |-> !stat.busy,
        "command while busy")
    `RM_ASSERT(a_one_cmd, clk, rst_n, !(cmd.push && cmd.pop), "push and pop together")
endmodule
`default_nettype wire

// ===== sv/running_median_two_heaps_unit.sv =====
// The time from input accept to result accept is set by the heap sift loops and the
// rebalance step.
// Throughput: one sample at a time; ready is low from accept until the result is taken.
// Rejected samples (store full) skip the heaps and go straight from idle to the output state.
// Reset (rst_n, asynchronous, active low) empties both heaps; memories need no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "running_median_two_heaps_unit_macros.svh"
module running_median_two_heaps_unit (
    input wire logic clk,
    input wire logic rst_n,
    rmth_in_if.sink  in_ch,
    rmth_out_if.source out_ch
);
    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_INS = 3'd1;
    localparam logic [2:0] P_BAL = 3'd2;
    localparam logic [2:0] P_POP = 3'd3;
    localparam logic [2:0] P_WAIT = 3'd4;
    localparam logic [2:0] P_OUT = 3'd5;

    logic [2:0] st_reg, st_next;
    rmth_pkg::sample_t smp_reg;
    logic bal_up_reg;
    logic rej_reg;
    rmth_pkg::heap_cmd_t ucmd, lcmd;
    rmth_pkg::heap_stat_t ust, lst;

    rmth_heap u_upper (.clk(clk), .rst_n(rst_n), .is_max(1'b0), .cmd(ucmd), .stat(ust));
    rmth_heap u_lower (.clk(clk), .rst_n(rst_n), .is_max(1'b1), .cmd(lcmd), .stat(lst));

    logic busy;
    logic [rmth_pkg::TW-1:0] total;
    assign busy = ust.busy || lst.busy;
    assign total = rmth_pkg::TW'(ust.size) + rmth_pkg::TW'(lst.size);
    assign in_ch.ready = (st_reg == P_IDLE);

    // Sequencer: insert, rebalance push, rebalance pop
    always_comb
    begin
        st_next = st_reg;
        ucmd = '0;
        lcmd = '0;
        ucmd.value = smp_reg;
        lcmd.value = smp_reg;
        unique case (st_reg)
            P_IDLE:
            begin
                if (in_ch.valid)
                begin
                    st_next = (total >= rmth_pkg::TW'(rmth_pkg::CAPACITY)) ? P_OUT : P_INS;
                end
            end
            P_INS:
            begin
                if (ust.size == '0 || smp_reg >= ust.top)
                begin
                    ucmd.push = 1'b1;
                end
                else
                begin
                    lcmd.push = 1'b1;
                end
                st_next = P_WAIT;
            end
            P_WAIT:
            begin
                if (!busy)
                begin
                    st_next = P_BAL;
                end
            end
            P_BAL:
            begin
                if (ust.size > lst.size + 1'b1)
                begin
                    lcmd.push = 1'b1;
                    lcmd.value = ust.top;
                    st_next = P_POP;
                end
                else if (lst.size > ust.size)
                begin
                    ucmd.push = 1'b1;
                    ucmd.value = lst.top;
                    st_next = P_POP;
                end
                else
                begin
                    st_next = P_OUT;
                end
            end
            P_POP:
            begin
                // pop the heap that was not pushed
                ucmd.pop = bal_up_reg ? 1'b0 : 1'b1;
                lcmd.pop = bal_up_reg;
                st_next = P_WAIT;
            end
            P_OUT:
            begin
                if (!busy && out_ch.valid && out_ch.ready)
                begin
                    st_next = P_IDLE;
                end
            end
            default:
            begin
                st_next = P_IDLE;
            end
        endcase
    end

    logic out_vld_reg;
    logic popped_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= P_IDLE;
            out_vld_reg <= 1'b0;
            popped_reg <= 1'b0;
        end
        else
        begin
            if (st_reg == P_POP)
            begin
                popped_reg <= 1'b1;
            end
            else if (st_reg == P_IDLE)
            begin
                popped_reg <= 1'b0;
            end
            // after a pop the balance is done
            if (st_reg == P_WAIT && !busy && popped_reg)
            begin
                st_reg <= P_OUT;
            end
            else
            begin
                st_reg <= st_next;
            end
            if (out_vld_reg && out_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            else if (st_reg == P_OUT && !busy && !out_vld_reg)
            begin
                out_vld_reg <= 1'b1;
            end
        end
    end

    assign out_ch.valid = out_vld_reg;

    // Hold the sample and the rebalance direction
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            smp_reg <= in_ch.sample;
            rej_reg <= (total >= rmth_pkg::TW'(rmth_pkg::CAPACITY));
        end
        if (st_reg == P_BAL)
        begin
            bal_up_reg <= !(ust.size > lst.size + 1'b1);
        end
    end

    // Result: wide sum of both tops, or twice the upper top when the upper heap holds one more
    logic signed [32:0] up_w, lo_w;
    assign up_w = (ust.size != '0) ? 33'(ust.top) : '0;
    assign lo_w = (lst.size != '0) ? 33'(lst.top) : '0;
    assign out_ch.median_doubled = (ust.size == lst.size) ? (up_w + lo_w) : (up_w <<< 1);
    assign out_ch.stored_count = 11'(total);
    assign out_ch.rejected = rej_reg;

    `RM_ASSERT(a_bal, clk, rst_n,
        out_ch.valid |-> (ust.size == lst.size || ust.size == lst.size + 1'b1),
        "heaps out of balance at result")
    `RM_ASSERT(a_ready, clk, rst_n, out_ch.valid |-> !in_ch.ready, "ready while result pending")
    `RM_ASSERT(a_cap, clk, rst_n, total <= rmth_pkg::TW'(rmth_pkg::CAPACITY), "store over capacity")
endmodule
`default_nettype wire
